// ===== rtl/core/rgbab_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbab_pkg
// Shared types and constants for the A1R5G5B5 alpha blit writeback unit.
// ----------------------------------------------------------------------------
package rgbab_pkg;

    localparam int PIX_W      = 16;
    localparam int CH_BITS    = 5;
    localparam int IDX_W      = 22;
    localparam int DIM_W      = 11;
    localparam int PITCH_W    = 13;
    localparam int OPA_W      = 8;
    localparam int M_W        = OPA_W - 3;
    localparam int CMP_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int MAX_DIM_DEFAULT = 1024;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    localparam logic [OPA_W-1:0] OPACITY_NONE   = 8'd0;
    localparam logic [OPA_W-1:0] OPACITY_OPAQUE = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLIT_MODE    = 3'd0,
        REG_OPACITY      = 3'd1,
        REG_SOURCE_KEYED = 3'd2,
        REG_RECT_WIDTH   = 3'd3,
        REG_RECT_HEIGHT  = 3'd4,
        REG_DEST_PITCH   = 3'd5,
        REG_DEST_START   = 3'd6
    } reg_index_t;

    typedef enum logic {
        MODE_OVER = 1'b0,
        MODE_COPY = 1'b1
    } blit_mode_t;

    typedef enum logic [1:0] {
        ACT_KEEP  = 2'd0,
        ACT_COPY  = 2'd1,
        ACT_BLEND = 2'd2
    } action_t;

    typedef struct packed {
        blit_mode_t          blit_mode;
        logic [OPA_W-1:0]    opacity;
        logic                source_keyed;
        logic [DIM_W-1:0]    rect_width;
        logic [DIM_W-1:0]    rect_height;
        logic [PITCH_W-1:0]  dest_pitch;
        logic [IDX_W-1:0]    dest_start;
    } cfg_t;

    typedef struct packed {
        action_t             action;
        logic [M_W-1:0]      weight;
        logic [PIX_W-1:0]    src_px;
        logic [PIX_W-1:0]    dst_px;
        logic [IDX_W-1:0]    dest_index;
        logic                last_pixel;
    } entry_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    typedef struct packed {
        logic pop;
        logic nonempty;
    } q_rd_t;

endpackage

// ===== rtl/core/rgb555_alpha_blit_unit.sv =====
// Path: an accepted item is written into the queue, then into the output
//   register, where out_valid rises; out_stall can hold it in the queue.
// Throughput: one item per cycle; a 4-entry queue between front and back
//   absorbs output stalls, in_stall rises only when that queue is full.
// Reset: registers return to their defaults, the rectangle walk restarts at
//   the top-left corner, queue and output register are emptied.
// ----------------------------------------------------------------------------
// rgb555_alpha_blit_unit
// A1R5G5B5 constant-opacity blit writeback: configuration registers, front
// classifier, item queue and blending back end.
// ----------------------------------------------------------------------------
module rgb555_alpha_blit_unit #(
    parameter int MAX_DIM = rgbab_pkg::MAX_DIM_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rgbab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbab_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rgbab_pkg::PIX_W-1:0]        src_px,
    input  logic [rgbab_pkg::PIX_W-1:0]        dst_px,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rgbab_pkg::PIX_W-1:0]        out_pixel,
    output logic                               write_enable,
    output logic [rgbab_pkg::IDX_W-1:0]        dest_index,
    output logic                               last_pixel
);

    rgbab_pkg::cfg_t     cfg_reg;
    rgbab_pkg::entry_t   push_entry, head_entry;
    rgbab_pkg::q_wr_t    wr_stat;
    rgbab_pkg::q_rd_t    rd_ctl;
    logic                push;
    logic                head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blit_mode    <= rgbab_pkg::MODE_OVER;
            cfg_reg.opacity      <= rgbab_pkg::OPACITY_OPAQUE;
            cfg_reg.source_keyed <= 1'b0;
            cfg_reg.rect_width   <= rgbab_pkg::DIM_W'(1);
            cfg_reg.rect_height  <= rgbab_pkg::DIM_W'(1);
            cfg_reg.dest_pitch   <= rgbab_pkg::PITCH_W'(1);
            cfg_reg.dest_start   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rgbab_pkg::reg_index_t'(cfg_index))
                rgbab_pkg::REG_BLIT_MODE:
                    cfg_reg.blit_mode <= rgbab_pkg::blit_mode_t'(cfg_data[0]);
                rgbab_pkg::REG_OPACITY:
                    cfg_reg.opacity <= cfg_data[rgbab_pkg::OPA_W-1:0];
                rgbab_pkg::REG_SOURCE_KEYED:
                    cfg_reg.source_keyed <= cfg_data[0];
                rgbab_pkg::REG_RECT_WIDTH:
                    cfg_reg.rect_width <= cfg_data[rgbab_pkg::DIM_W-1:0];
                rgbab_pkg::REG_RECT_HEIGHT:
                    cfg_reg.rect_height <= cfg_data[rgbab_pkg::DIM_W-1:0];
                rgbab_pkg::REG_DEST_PITCH:
                    cfg_reg.dest_pitch <= cfg_data[rgbab_pkg::PITCH_W-1:0];
                rgbab_pkg::REG_DEST_START:
                    cfg_reg.dest_start <= cfg_data[rgbab_pkg::IDX_W-1:0];
                default:
                begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    rgbab_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_px    (src_px),
        .dst_px    (dst_px),
        .q_full    (wr_stat.full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    rgbab_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (push_entry),
        .wr_stat  (wr_stat),
        .pop      (rd_ctl.pop),
        .rd_entry (head_entry),
        .nonempty (head_valid)
    );

    rgbab_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_entry),
        .head_valid   (head_valid),
        .rd_ctl       (rd_ctl),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_pixel    (out_pixel),
        .write_enable (write_enable),
        .dest_index   (dest_index),
        .last_pixel   (last_pixel)
    );

    a_push_matches: assert property (@(posedge clk) disable iff (!rst_n)
        wr_stat.push == (in_valid && !in_stall))
        else $error("queue push differs from input acceptance");

    a_head_seen: assert property (@(posedge clk) disable iff (!rst_n)
        rd_ctl.nonempty == head_valid)
        else $error("back end sees stale queue status");

endmodule

// ===== rtl/core/rgbab_front.sv =====
// ----------------------------------------------------------------------------
// rgbab_front
// Accepts pixel pairs, picks the action, and walks the rectangle to form the
// destination index and last-pixel mark.
// ----------------------------------------------------------------------------
module rgbab_front #(
    parameter int MAX_DIM = rgbab_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rgbab_pkg::cfg_t               cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rgbab_pkg::PIX_W-1:0]   src_px,
    input  logic [rgbab_pkg::PIX_W-1:0]   dst_px,
    input  logic                          q_full,
    output logic                          q_push,
    output rgbab_pkg::entry_t             q_entry
);

    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [rgbab_pkg::CMP_W-1:0] DIM_LIMIT = rgbab_pkg::CMP_W'(MAX_DIM);

    logic [CW-1:0]                 col_reg, col_next;
    logic [CW-1:0]                 row_reg, row_next;
    logic [rgbab_pkg::IDX_W-1:0]   row_base_reg, row_base_next;

    logic [rgbab_pkg::CMP_W-1:0]   w_raw, h_raw, w_eff, h_eff, col_p1, row_p1;
    logic                          row_end, last;
    logic                          accept;
    logic                          alpha;
    rgbab_pkg::action_t            action;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // zero counts as one, oversize saturates
    assign w_raw = rgbab_pkg::CMP_W'(cfg.rect_width);
    assign h_raw = rgbab_pkg::CMP_W'(cfg.rect_height);
    assign w_eff = (w_raw == '0) ? rgbab_pkg::CMP_W'(1) :
                   ((w_raw > DIM_LIMIT) ? DIM_LIMIT : w_raw);
    assign h_eff = (h_raw == '0) ? rgbab_pkg::CMP_W'(1) :
                   ((h_raw > DIM_LIMIT) ? DIM_LIMIT : h_raw);

    assign col_p1  = rgbab_pkg::CMP_W'(col_reg) + rgbab_pkg::CMP_W'(1);
    assign row_p1  = rgbab_pkg::CMP_W'(row_reg) + rgbab_pkg::CMP_W'(1);
    assign row_end = (col_p1 >= w_eff);
    assign last    = row_end && (row_p1 >= h_eff);

    assign alpha = src_px[rgbab_pkg::PIX_W-1];

    always_comb
    begin
        action = rgbab_pkg::ACT_KEEP;
        priority if (cfg.opacity == rgbab_pkg::OPACITY_NONE)
        begin
            action = rgbab_pkg::ACT_KEEP;
        end
        else if (cfg.blit_mode == rgbab_pkg::MODE_COPY)
        begin
            action = rgbab_pkg::ACT_COPY;
        end
        else if (cfg.opacity == rgbab_pkg::OPACITY_OPAQUE)
        begin
            action = alpha ? rgbab_pkg::ACT_COPY : rgbab_pkg::ACT_KEEP;
        end
        else if (!cfg.source_keyed || alpha)
        begin
            action = rgbab_pkg::ACT_BLEND;
        end
        else
        begin
            action = rgbab_pkg::ACT_KEEP;
        end
    end

    always_comb
    begin
        q_entry.action     = action;
        q_entry.weight     = cfg.opacity[rgbab_pkg::OPA_W-1:3];
        q_entry.src_px     = src_px;
        q_entry.dst_px     = dst_px;
        q_entry.dest_index = cfg.dest_start + row_base_reg
                             + rgbab_pkg::IDX_W'(col_reg);
        q_entry.last_pixel = last;
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (accept)
        begin
            priority if (last)
            begin
                col_next      = '0;
                row_next      = '0;
                row_base_next = '0;
            end
            else if (row_end)
            begin
                col_next      = '0;
                row_next      = row_reg + CW'(1);
                row_base_next = row_base_reg + rgbab_pkg::IDX_W'(cfg.dest_pitch);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
        end
    end

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> (col_reg == '0) && (row_reg == '0) && (row_base_reg == '0))
        else $error("walk did not restart after last pixel");

    a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !row_end |=> col_reg == $past(col_reg) + CW'(1))
        else $error("column counter did not advance");

endmodule

// ===== rtl/core/rgbab_queue.sv =====
// ----------------------------------------------------------------------------
// rgbab_queue
// Short item queue between the classifying front and the blending back.
// ----------------------------------------------------------------------------
module rgbab_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rgbab_pkg::entry_t    wr_entry,
    output rgbab_pkg::q_wr_t     wr_stat,
    input  logic                 pop,
    output rgbab_pkg::entry_t    rd_entry,
    output logic                 nonempty
);

    rgbab_pkg::entry_t             q_mem [rgbab_pkg::Q_DEPTH];
    logic [rgbab_pkg::Q_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [rgbab_pkg::Q_AW:0]      count_reg, count_next;
    logic                          full;

    assign full     = (count_reg == (rgbab_pkg::Q_AW + 1)'(rgbab_pkg::Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_entry = q_mem[rd_ptr_reg];

    assign wr_stat.push = push;
    assign wr_stat.full = full;

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (rgbab_pkg::Q_AW + 1)'(1);
            2'b01:   count_next = count_reg - (rgbab_pkg::Q_AW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rgbab_pkg::Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rgbab_pkg::Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (rgbab_pkg::Q_AW + 1)'(rgbab_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty && !(push && full))
        else $error("queue popped empty or pushed full");

endmodule

// ===== rtl/core/rgbab_back.sv =====
// ----------------------------------------------------------------------------
// rgbab_back
// Carries out the chosen action on the head item and holds the result in
// the output register.
// ----------------------------------------------------------------------------
module rgbab_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rgbab_pkg::entry_t             head,
    input  logic                          head_valid,
    output rgbab_pkg::q_rd_t              rd_ctl,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rgbab_pkg::PIX_W-1:0]   out_pixel,
    output logic                          write_enable,
    output logic [rgbab_pkg::IDX_W-1:0]   dest_index,
    output logic                          last_pixel
);

    localparam int CB   = rgbab_pkg::CH_BITS;
    localparam int SUMW = 2 * CB;

    logic                          out_valid_reg;
    logic [rgbab_pkg::PIX_W-1:0]   pixel_reg, pixel_next;
    logic                          we_reg, we_next;
    logic [rgbab_pkg::IDX_W-1:0]   index_reg;
    logic                          last_reg;
    logic                          pop;
    logic [CB:0]                   inv_w;
    logic [rgbab_pkg::PIX_W-1:0]   blended;

    function automatic logic [CB-1:0] mix(input logic [CB-1:0] s,
                                          input logic [CB-1:0] d,
                                          input logic [CB-1:0] m,
                                          input logic [CB:0]   im);
        logic [SUMW-1:0] acc;
        acc = SUMW'(s * m) + SUMW'(d * im);
        return acc[SUMW-1:CB];
    endfunction

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    assign rd_ctl.pop      = pop;
    assign rd_ctl.nonempty = head_valid;

    assign inv_w = (CB + 1)'(1 << CB) - (CB + 1)'(head.weight);

    assign blended = {1'b1,
        mix(head.src_px[3*CB-1:2*CB], head.dst_px[3*CB-1:2*CB], head.weight, inv_w),
        mix(head.src_px[2*CB-1:CB],   head.dst_px[2*CB-1:CB],   head.weight, inv_w),
        mix(head.src_px[CB-1:0],      head.dst_px[CB-1:0],      head.weight, inv_w)};

    always_comb
    begin
        unique case (head.action)
            rgbab_pkg::ACT_COPY:
            begin
                pixel_next = head.src_px;
                we_next    = 1'b1;
            end
            rgbab_pkg::ACT_BLEND:
            begin
                pixel_next = blended;
                we_next    = 1'b1;
            end
            default:
            begin
                pixel_next = head.dst_px;
                we_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pixel_reg <= pixel_next;
            we_reg    <= we_next;
            index_reg <= head.dest_index;
            last_reg  <= head.last_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pixel    = pixel_reg;
    assign write_enable = we_reg;
    assign dest_index   = index_reg;
    assign last_pixel   = last_reg;

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped item not presented");

endmodule

// ===== test/rgb555_alpha_blit_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rgb555_alpha_blit_unit_tb
// Self-checking bench for the A1R5G5B5 blit writeback unit: a table of
// directed pixels, then random phases of register settings and pixel bursts
// with random gaps and stalls on both sides, each result checked in order.
// ----------------------------------------------------------------------------
module rgb555_alpha_blit_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W      = rgbab_pkg::PIX_W;
    localparam int IDX_W      = rgbab_pkg::IDX_W;
    localparam int DIM_W      = rgbab_pkg::DIM_W;
    localparam int PITCH_W    = rgbab_pkg::PITCH_W;
    localparam int OPA_W      = rgbab_pkg::OPA_W;
    localparam int M_W        = rgbab_pkg::M_W;
    localparam int CH_BITS    = rgbab_pkg::CH_BITS;
    localparam int CFG_IDX_W  = rgbab_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = rgbab_pkg::CFG_DATA_W;
    localparam int MAX_DIM    = rgbab_pkg::MAX_DIM_DEFAULT;

    localparam int RANDOM_ITEMS   = 670;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             we;
        logic [IDX_W-1:0] index;
        logic             last;
    } blit_result_t;

    typedef struct {
        rgbab_pkg::cfg_t  settings;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
        bit               typed;
        blit_result_t     want;
    } stim_row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      src_px       = '0;
    logic [PIX_W-1:0]      dst_px       = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [PIX_W-1:0]      out_pixel;
    logic                  write_enable;
    logic [IDX_W-1:0]      dest_index;
    logic                  last_pixel;

    // register shadow and rectangle walk of the predictor
    rgbab_pkg::cfg_t       blit_cfg;
    logic [9:0]            walk_col      = '0;
    logic [9:0]            walk_row      = '0;
    logic [IDX_W-1:0]      walk_row_base = '0;

    blit_result_t          pending_writes[$];
    blit_result_t          oldest;
    stim_row_t             directed_rows[$];
    int unsigned           error_count   = 0;
    int unsigned           idle_cycles   = 0;
    int unsigned           hold_requests = 0;
    bit                    steady_in     = 1'b0;
    bit                    steady_out    = 1'b0;

    rgb555_alpha_blit_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .src_px       (src_px),
        .dst_px       (dst_px),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_pixel    (out_pixel),
        .write_enable (write_enable),
        .dest_index   (dest_index),
        .last_pixel   (last_pixel)
    );

    always #1 clk = ~clk;

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [CH_BITS-1:0] blend_channel(logic [CH_BITS-1:0] s,
                                                         logic [CH_BITS-1:0] d,
                                                         logic [M_W-1:0] m);
        int unsigned acc;
        acc = int'(s) * int'(m) + (32 - int'(m)) * int'(d);
        return CH_BITS'(acc >> CH_BITS);
    endfunction

    // Works out one result and advances the walk, as the block does per item
    function automatic blit_result_t predict_writeback(logic [PIX_W-1:0] s,
                                                       logic [PIX_W-1:0] d);
        blit_result_t   res;
        int unsigned    w;
        int unsigned    h;
        logic [M_W-1:0] m;
        logic           row_end;
        w = clamp_dim(blit_cfg.rect_width);
        h = clamp_dim(blit_cfg.rect_height);
        m = blit_cfg.opacity[OPA_W-1:3];
        res.pixel = d;
        res.we    = 1'b0;
        res.index = blit_cfg.dest_start + walk_row_base + IDX_W'(walk_col);
        row_end   = (int'(walk_col) + 1 >= w);
        res.last  = row_end && (int'(walk_row) + 1 >= h);

        if (blit_cfg.opacity != rgbab_pkg::OPACITY_NONE)
        begin
            if (blit_cfg.blit_mode == rgbab_pkg::MODE_COPY)
            begin
                res.pixel = s;
                res.we    = 1'b1;
            end
            else if (blit_cfg.opacity == rgbab_pkg::OPACITY_OPAQUE)
            begin
                if (s[15])
                begin
                    res.pixel = s;
                    res.we    = 1'b1;
                end
            end
            else if (!blit_cfg.source_keyed || s[15])
            begin
                res.pixel = {1'b1,
                             blend_channel(s[14:10], d[14:10], m),
                             blend_channel(s[9:5], d[9:5], m),
                             blend_channel(s[4:0], d[4:0], m)};
                res.we    = 1'b1;
            end
        end

        if (res.last)
        begin
            walk_col      = '0;
            walk_row      = '0;
            walk_row_base = '0;
        end
        else if (row_end)
        begin
            walk_col      = '0;
            walk_row      = walk_row + 1'b1;
            walk_row_base = walk_row_base + IDX_W'(blit_cfg.dest_pitch);
        end
        else
        begin
            walk_col = walk_col + 1'b1;
        end
        return res;
    endfunction

    function automatic rgbab_pkg::cfg_t blit_settings(rgbab_pkg::blit_mode_t mode,
                                                      logic [OPA_W-1:0] opa,
                                                      logic keyed,
                                                      logic [DIM_W-1:0] w,
                                                      logic [DIM_W-1:0] h,
                                                      logic [PITCH_W-1:0] pitch,
                                                      logic [IDX_W-1:0] start);
        rgbab_pkg::cfg_t c;
        c.blit_mode    = mode;
        c.opacity      = opa;
        c.source_keyed = keyed;
        c.rect_width   = w;
        c.rect_height  = h;
        c.dest_pitch   = pitch;
        c.dest_start   = start;
        return c;
    endfunction

    function automatic void add_row(rgbab_pkg::cfg_t c, logic [PIX_W-1:0] s,
                                    logic [PIX_W-1:0] d, bit typed,
                                    logic [PIX_W-1:0] pix, logic we,
                                    logic [IDX_W-1:0] idx, logic last);
        stim_row_t row;
        row.settings   = c;
        row.src        = s;
        row.dst        = d;
        row.typed      = typed;
        row.want.pixel = pix;
        row.want.we    = we;
        row.want.index = idx;
        row.want.last  = last;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return DIM_W'(MAX_DIM);
            2:       return DIM_W'($urandom_range(MAX_DIM + 1, 2047));
            3:       return DIM_W'($urandom_range(7, 40));
            default: return DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic rgbab_pkg::cfg_t random_settings();
        rgbab_pkg::cfg_t c;
        c.blit_mode = ($urandom_range(0, 2) == 0) ? rgbab_pkg::MODE_COPY
                                                  : rgbab_pkg::MODE_OVER;
        case ($urandom_range(0, 9))
            0:       c.opacity = rgbab_pkg::OPACITY_NONE;
            1, 2:    c.opacity = rgbab_pkg::OPACITY_OPAQUE;
            3:       c.opacity = OPA_W'($urandom_range(1, 7));
            4:       c.opacity = 8'd254;
            default: c.opacity = OPA_W'($urandom_range(0, 255));
        endcase
        c.source_keyed = 1'($urandom_range(0, 1));
        c.rect_width   = random_dim();
        c.rect_height  = random_dim();
        case ($urandom_range(0, 5))
            0:       c.dest_pitch = '0;
            1:       c.dest_pitch = '1;
            2:       c.dest_pitch = 13'd1;
            default: c.dest_pitch = PITCH_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       c.dest_start = '0;
            1:       c.dest_start = '1;
            default: c.dest_start = IDX_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // random junk above the register width, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] pad_upper(logic [CFG_DATA_W-1:0] v,
                                                        int bits);
        logic [CFG_DATA_W-1:0] keep;
        keep = (bits >= CFG_DATA_W) ? '1
                                    : ((CFG_DATA_W'(1) << bits) - CFG_DATA_W'(1));
        return (CFG_DATA_W'($urandom) & ~keep) | (v & keep);
    endfunction

    task automatic write_reg(rgbab_pkg::reg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            rgbab_pkg::REG_BLIT_MODE:
                blit_cfg.blit_mode = rgbab_pkg::blit_mode_t'(data[0]);
            rgbab_pkg::REG_OPACITY:      blit_cfg.opacity      = data[OPA_W-1:0];
            rgbab_pkg::REG_SOURCE_KEYED: blit_cfg.source_keyed = data[0];
            rgbab_pkg::REG_RECT_WIDTH:   blit_cfg.rect_width   = data[DIM_W-1:0];
            rgbab_pkg::REG_RECT_HEIGHT:  blit_cfg.rect_height  = data[DIM_W-1:0];
            rgbab_pkg::REG_DEST_PITCH:   blit_cfg.dest_pitch   = data[PITCH_W-1:0];
            rgbab_pkg::REG_DEST_START:   blit_cfg.dest_start   = data[IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(rgbab_pkg::cfg_t c);
        write_reg(rgbab_pkg::REG_BLIT_MODE,    pad_upper(c.blit_mode, 1));
        write_reg(rgbab_pkg::REG_OPACITY,      pad_upper(c.opacity, OPA_W));
        write_reg(rgbab_pkg::REG_SOURCE_KEYED, pad_upper(c.source_keyed, 1));
        write_reg(rgbab_pkg::REG_RECT_WIDTH,   pad_upper(c.rect_width, DIM_W));
        write_reg(rgbab_pkg::REG_RECT_HEIGHT,  pad_upper(c.rect_height, DIM_W));
        write_reg(rgbab_pkg::REG_DEST_PITCH,   pad_upper(c.dest_pitch, PITCH_W));
        write_reg(rgbab_pkg::REG_DEST_START,   pad_upper(c.dest_start, IDX_W));
        cfg_valid <= 1'b0;
    endtask

    // stop offering, let every result come out, then wait on with nothing in flight
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] s, logic [PIX_W-1:0] d, bit typed,
                              blit_result_t want);
        blit_result_t predicted;
        int unsigned  gap;
        gap = steady_in ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        src_px   <= s;
        dst_px   <= d;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted = predict_writeback(s, d);
        pending_writes.push_back(typed ? want : predicted);
    endtask

    initial
    begin
        rgbab_pkg::cfg_t reset_cfg;
        rgbab_pkg::cfg_t c;
        blit_result_t    no_typed;
        int              k;
        int              n;
        int              phase_no;
        int              random_sent;

        reset_cfg = blit_settings(rgbab_pkg::MODE_OVER, rgbab_pkg::OPACITY_OPAQUE, 1'b0,
                                  11'd1, 11'd1, 13'd1, '0);
        blit_cfg  = reset_cfg;
        no_typed  = '{default: '0};

        add_row(reset_cfg, 16'hFFFF, 16'h0000, 1, 16'hFFFF, 1'b1, 22'd0, 1'b1);
        add_row(reset_cfg, 16'h7FFF, 16'h1234, 1, 16'h1234, 1'b0, 22'd0, 1'b1);
        add_row(reset_cfg, 16'h8000, 16'h7FFF, 1, 16'h8000, 1'b1, 22'd0, 1'b1);
        c = blit_settings(rgbab_pkg::MODE_COPY, rgbab_pkg::OPACITY_OPAQUE, 1'b0,
                          11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'h0000, 16'hFFFF, 1, 16'h0000, 1'b1, 22'd0, 1'b1);
        c = blit_settings(rgbab_pkg::MODE_COPY, rgbab_pkg::OPACITY_NONE, 1'b0,
                          11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'hFFFF, 16'h2AAA, 1, 16'h2AAA, 1'b0, 22'd0, 1'b1);
        c = blit_settings(rgbab_pkg::MODE_OVER, rgbab_pkg::OPACITY_NONE, 1'b0,
                          11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'hFFFF, 16'h5555, 1, 16'h5555, 1'b0, 22'd0, 1'b1);
        c = blit_settings(rgbab_pkg::MODE_OVER, 8'd128, 1'b0, 11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'h7FFF, 16'h0000, 0, '0, 1'b0, '0, 1'b0);
        // weight zero keeps the destination colour but still sets alpha
        c = blit_settings(rgbab_pkg::MODE_OVER, 8'd7, 1'b0, 11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'hFFFF, 16'h1234, 1, 16'h9234, 1'b1, 22'd0, 1'b1);
        c = blit_settings(rgbab_pkg::MODE_OVER, 8'd1, 1'b0, 11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'h0000, 16'h7FFF, 0, '0, 1'b0, '0, 1'b0);
        c = blit_settings(rgbab_pkg::MODE_OVER, 8'd254, 1'b0, 11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'hFFFF, 16'h0000, 0, '0, 1'b0, '0, 1'b0);
        c = blit_settings(rgbab_pkg::MODE_OVER, 8'd100, 1'b1, 11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'h7FFF, 16'hABCD, 1, 16'hABCD, 1'b0, 22'd0, 1'b1);
        add_row(c, 16'h8421, 16'h7BDE, 0, '0, 1'b0, '0, 1'b0);
        // opaque over tests alpha even when keying is off or on
        c = blit_settings(rgbab_pkg::MODE_OVER, rgbab_pkg::OPACITY_OPAQUE, 1'b1,
                          11'd1, 11'd1, 13'd1, '0);
        add_row(c, 16'h0001, 16'h4321, 1, 16'h4321, 1'b0, 22'd0, 1'b1);
        // zero sizes count as one
        c = blit_settings(rgbab_pkg::MODE_COPY, rgbab_pkg::OPACITY_OPAQUE, 1'b0,
                          11'd0, 11'd0, 13'd1, '1);
        add_row(c, 16'h1111, 16'h0000, 1, 16'h1111, 1'b1, '1, 1'b1);
        // 3x2 walk with largest pitch, index wraps
        c = blit_settings(rgbab_pkg::MODE_OVER, 8'd200, 1'b0, 11'd3, 11'd2, '1,
                          22'h3FFFFE);
        for (k = 0; k < 6; k++)
            add_row(c, 16'h8000 ^ PIX_W'(16'h1357 * k), 16'hFFFF - PIX_W'(k * 16'h0842),
                    0, '0, 1'b0, '0, 1'b0);
        // pitch zero: both rows land on the same indices
        c = blit_settings(rgbab_pkg::MODE_COPY, rgbab_pkg::OPACITY_OPAQUE, 1'b0,
                          11'd2, 11'd2, '0, 22'd5);
        for (k = 0; k < 4; k++)
            add_row(c, PIX_W'(16'h0F0F << k), 16'h0000, 0, '0, 1'b0, '0, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].settings != blit_cfg)
            begin
                settle_pipeline();
                load_settings(directed_rows[i].settings);
            end
            send_pixel(directed_rows[i].src, directed_rows[i].dst,
                       directed_rows[i].typed, directed_rows[i].want);
        end

        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            c = random_settings();
            settle_pipeline();
            load_settings(c);
            if (phase_no % 8 == 2)
            begin
                // back end held off while items keep coming, so the queue fills
                hold_requests++;
                steady_in = 1'b1;
                n         = 30;
            end
            else
            begin
                steady_in = ($urandom_range(0, 3) == 0);
                n         = $urandom_range(8, 48);
            end
            for (k = 0; k < n; k++)
                send_pixel(random_pixel(), random_pixel(), 1'b0, no_typed);
            random_sent += n;
            phase_no++;
        end

        settle_pipeline();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("rgb555_alpha_blit_unit verification clean");
        else
            $display("rgb555_alpha_blit_unit verification failed");
        $finish;
    end

    // receiving side: random stall before each item, calm stretches, long holds
    initial
    begin
        int unsigned hold;
        int unsigned holds_taken;
        holds_taken = 0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                steady_out = !steady_out;
            hold = steady_out ? 0 : $urandom_range(0, 14);
            if (hold_requests != holds_taken)
            begin
                hold        = HOLD_CYCLES;
                holds_taken = hold_requests;
            end
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("result with nothing expected: out_pixel %h dest_index %h",
                       out_pixel, dest_index);
                error_count++;
            end
            else
            begin
                oldest = pending_writes.pop_front();
                if (out_pixel !== oldest.pixel)
                begin
                    $error("out_pixel: expected %h, got %h", oldest.pixel, out_pixel);
                    error_count++;
                end
                if (write_enable !== oldest.we)
                begin
                    $error("write_enable: expected %b, got %b", oldest.we, write_enable);
                    error_count++;
                end
                if (dest_index !== oldest.index)
                begin
                    $error("dest_index: expected %h, got %h", oldest.index, dest_index);
                    error_count++;
                end
                if (last_pixel !== oldest.last)
                begin
                    $error("last_pixel: expected %b, got %b", oldest.last, last_pixel);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
            (cfg_valid && cfg_ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rgb555_alpha_blit_unit verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
